>>> sv/mca_pkg.sv
// Shared types and constants of the min-cost assignment solver.
// Used by mca_solver and min_cost_assignment_solver; no dependencies.
`default_nettype none
package mca_pkg;

    localparam int MAX_SIZE  = 16;
    localparam int COST_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_SIZE);
    localparam int N_W       = IDX_W + 1;
    localparam int MEM_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int W_W       = COST_BITS + 1;
    localparam int LAB_W     = COST_BITS + 4;
    localparam int TOT_W     = COST_BITS + 4;

    typedef logic signed [COST_BITS-1:0] t_cost;
    typedef logic signed [W_W-1:0]       t_wgt;
    typedef logic signed [LAB_W-1:0]     t_lab;
    // partner / parent pointer: top bit set means none
    typedef logic [IDX_W:0]              t_ptn;

    localparam t_ptn  PTN_NONE = t_ptn'(1) << IDX_W;
    localparam t_cost COST_MIN = t_cost'(1) << (COST_BITS - 1);

    // weight memory request from the solver
    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        t_wgt              wdata;
        logic [MEM_AW-1:0] raddr;
    } t_mem_req;

    // solver status toward the loader
    typedef struct packed {
        logic busy;
        logic done;
    } t_sol_stat;

endpackage
`default_nettype wire

>>> sv/min_cost_assignment_solver.sv
// Min-cost assignment solver top level: matrix loader, weight RAM, solver.
// Depends on mca_pkg, mca_ram and mca_solver.
//
// Usage: write matrix_size (1..16, 0 acts as 1, above 16 as 16) through
// i_cfg_we/i_cfg_data while idle; a write drops any partial matrix.
// Then give n*n costs in row-major order, one transaction per cycle at most,
// with start high while busy is low. On the last element busy rises and the
// block solves the assignment (Hungarian method) out of the weight RAM.
// Each weight RAM read has an address state and a registered-data state.
// The solve runs weight conversion, then row maxima, then per round the
// initial slacks, the BFS row scans with tree growth, and label update
// passes (up to n+1 per round), over n rounds, and finally sums the cost.
// Results then come on consecutive cycles, o_valid high, one per row:
// row, assigned column, total cost, and o_last_result on row n-1. The
// receiver cannot stall; results are not held. busy falls after the last
// result and the next matrix can be loaded.
// Reset: matrix_size is 16, loading starts at element 0, solver is idle.
`default_nettype none
module min_cost_assignment_solver import mca_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_cfg_we,
    input  wire logic [N_W-1:0]          i_cfg_data,
    input  wire logic signed [COST_BITS-1:0] i_cost_value,
    output logic                         o_valid,
    output logic [IDX_W-1:0]             o_row_index,
    output logic [IDX_W-1:0]             o_column_index,
    output logic signed [TOT_W-1:0]      o_total_cost,
    output logic                         o_last_result
);

    logic [N_W-1:0]  r_size;
    logic [MEM_AW:0] r_cnt;
    t_cost           r_max;
    logic            r_go;

    logic [N_W-1:0]  w_n;
    logic [MEM_AW:0] w_tot;
    logic            w_accept;
    t_mem_req        w_req;
    t_sol_stat       w_stat;
    t_wgt            w_rd_data;

    // clamp the configured size into 1..MAX_SIZE
    assign w_n = (r_size == '0) ? N_W'(1)
               : (r_size > N_W'(MAX_SIZE)) ? N_W'(MAX_SIZE) : r_size;
    assign w_tot    = (MEM_AW+1)'(w_n) * (MEM_AW+1)'(w_n);
    assign busy     = r_go | w_stat.busy;
    assign w_accept = start && !busy;

    // loader: count elements and track the largest cost
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= N_W'(MAX_SIZE);
            r_cnt  <= '0;
            r_max  <= COST_MIN;
            r_go   <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
                r_cnt  <= '0;
                r_max  <= COST_MIN;
            end else if (w_stat.done) begin
                r_cnt <= '0;
                r_max <= COST_MIN;
            end else if (w_accept) begin
                if (i_cost_value > r_max) r_max <= i_cost_value;
                r_cnt <= r_cnt + (MEM_AW+1)'(1);
                r_go  <= (r_cnt + (MEM_AW+1)'(1) >= w_tot);
            end
        end
    end

    mca_ram #(
        .WIDTH(W_W),
        .DEPTH(MEM_DEPTH)
    ) u_wgt_ram (
        .i_clk  (i_clk),
        .i_we   (w_accept ? 1'b1 : w_req.we),
        .i_waddr(w_accept ? r_cnt[MEM_AW-1:0] : w_req.waddr),
        .i_wdata(w_accept ? W_W'(i_cost_value) : w_req.wdata),
        .i_raddr(w_req.raddr),
        .o_rdata(w_rd_data)
    );

    mca_solver u_solver (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (r_go),
        .i_n           (w_n),
        .i_max         (r_max),
        .i_rd_data     (w_rd_data),
        .o_mem         (w_req),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_row_index   (o_row_index),
        .o_column_index(o_column_index),
        .o_total_cost  (o_total_cost),
        .o_last_result (o_last_result)
    );

endmodule
`default_nettype wire

>>> sv/mca_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module mca_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> sv/mca_solver.sv
// Hungarian solver sequencer: weight conversion, labeling, BFS tree,
// augmentation and result emission. Depends on mca_pkg; drives mca_ram.
`default_nettype none
module mca_solver import mca_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [N_W-1:0]   i_n,
    input  wire t_cost            i_max,
    input  wire t_wgt             i_rd_data,
    output t_mem_req              o_mem,
    output t_sol_stat             o_stat,
    output logic                  o_valid,
    output logic [IDX_W-1:0]      o_row_index,
    output logic [IDX_W-1:0]      o_column_index,
    output logic signed [TOT_W-1:0] o_total_cost,
    output logic                  o_last_result
);

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_CONV_RD = 20'h00002,
        S_CONV_EX = 20'h00004,
        S_INIT_RD = 20'h00008,
        S_INIT_EX = 20'h00010,
        S_ROUND   = 20'h00020,
        S_RSL_RD  = 20'h00040,
        S_RSL_EX  = 20'h00080,
        S_POP     = 20'h00100,
        S_BFS_RD  = 20'h00200,
        S_BFS_EX  = 20'h00400,
        S_GRW_RD  = 20'h00800,
        S_GRW_EX  = 20'h01000,
        S_DMIN    = 20'h02000,
        S_DUPD    = 20'h04000,
        S_ZERO    = 20'h08000,
        S_AUG     = 20'h10000,
        S_SUM_RD  = 20'h20000,
        S_SUM_EX  = 20'h40000,
        S_OUT     = 20'h80000
    } t_state;

    t_state               r_state;
    logic [N_W-1:0]       r_n;
    t_cost                r_max;
    logic [MEM_AW:0]      r_idx;
    logic [IDX_W-1:0]     r_row, r_col, r_root, r_cur, r_gr, r_gc, r_er, r_ec, r_step;
    logic                 r_ret_zero;
    logic [N_W-1:0]       r_qr, r_qw, r_guard, r_round;
    t_lab                 r_acc, r_delta;
    logic                 r_have;
    logic signed [TOT_W-1:0] r_total;

    t_lab                 r_rlab  [MAX_SIZE];
    t_lab                 r_clab  [MAX_SIZE];
    t_lab                 r_slack [MAX_SIZE];
    t_ptn                 r_rpart [MAX_SIZE];
    t_ptn                 r_cpart [MAX_SIZE];
    t_ptn                 r_tpar  [MAX_SIZE];
    logic [IDX_W-1:0]     r_ssrc  [MAX_SIZE];
    logic [IDX_W-1:0]     r_queue [MAX_SIZE];
    logic [MAX_SIZE-1:0]  r_rtree, r_ctree;

    logic [IDX_W-1:0]     w_nm1, w_arow, w_acol, w_sum_col, w_root, w_p, w_src;
    logic                 w_root_hit;
    logic [MEM_AW:0]      w_addr, w_tot;
    t_lab                 w_wd, w_rsl, w_grw, w_bfs_sum;
    t_wgt                 w_orig;
    logic                 w_last_col, w_last_gc, w_last_row, w_aug_stop;
    t_ptn                 w_nc, w_par;

    assign w_nm1      = IDX_W'(r_n - N_W'(1));
    assign w_last_col = (r_col == w_nm1);
    assign w_last_gc  = (r_gc == w_nm1);
    assign w_last_row = (r_row == w_nm1);
    assign w_tot      = (MEM_AW+1)'(r_n) * (MEM_AW+1)'(r_n);
    assign w_wd       = LAB_W'(i_rd_data);
    // original cost back from a weight: max - weight
    assign w_orig     = W_W'(r_max) - i_rd_data;
    assign w_sum_col  = r_rpart[r_row][IDX_W] ? '0 : r_rpart[r_row][IDX_W-1:0];
    assign w_rsl      = r_rlab[r_root] + r_clab[r_col] - w_wd;
    assign w_grw      = r_rlab[r_gr] + r_clab[r_gc] - w_wd;
    assign w_bfs_sum  = r_rlab[r_cur] + r_clab[r_col];
    assign w_p        = r_cpart[r_col][IDX_W-1:0];
    assign w_src      = r_ssrc[r_col];

    // augment step: stop at the root, a free row, a broken parent link or the step limit
    assign w_nc       = r_rpart[r_er];
    assign w_par      = r_tpar[r_er];
    assign w_aug_stop = (r_er == r_root) || w_nc[IDX_W] || w_par[IDX_W]
                        || ({1'b0, w_par[IDX_W-1:0]} >= r_n) || (r_step == w_nm1);

    // first unmatched row
    always_comb begin
        w_root     = '0;
        w_root_hit = 1'b0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            if (!w_root_hit && N_W'(i) < r_n && r_rpart[i][IDX_W]) begin
                w_root     = IDX_W'(i);
                w_root_hit = 1'b1;
            end
        end
    end

    // weight memory address: row * n + column
    always_comb begin
        w_arow = r_row;
        w_acol = r_col;
        unique case (r_state)
            S_RSL_RD: w_arow = r_root;
            S_BFS_RD: w_arow = r_cur;
            S_GRW_RD: begin
                w_arow = r_gr;
                w_acol = r_gc;
            end
            S_SUM_RD: w_acol = w_sum_col;
            default: ;
        endcase
    end
    assign w_addr = (MEM_AW+1)'(w_arow) * (MEM_AW+1)'(r_n) + (MEM_AW+1)'(w_acol);

    assign o_mem.we    = (r_state == S_CONV_EX);
    assign o_mem.waddr = r_idx[MEM_AW-1:0];
    assign o_mem.wdata = w_orig;
    assign o_mem.raddr = (r_state == S_CONV_RD) ? r_idx[MEM_AW-1:0] : w_addr[MEM_AW-1:0];

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_OUT) && w_last_row;

    assign o_valid        = (r_state == S_OUT);
    assign o_row_index    = r_row;
    assign o_column_index = w_sum_col;
    assign o_total_cost   = r_total;
    assign o_last_result  = w_last_row;

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_qw    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_n     <= i_n;
                        r_max   <= i_max;
                        r_idx   <= '0;
                        r_state <= S_CONV_RD;
                    end
                end
                S_CONV_RD: r_state <= S_CONV_EX;
                S_CONV_EX: begin
                    if (r_idx == w_tot - (MEM_AW+1)'(1)) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= S_INIT_RD;
                    end else begin
                        r_idx   <= r_idx + (MEM_AW+1)'(1);
                        r_state <= S_CONV_RD;
                    end
                end
                S_INIT_RD: r_state <= S_INIT_EX;
                S_INIT_EX: begin
                    if (w_last_col) begin
                        r_rlab[r_row]  <= (r_col == '0 || w_wd > r_acc) ? w_wd : r_acc;
                        r_clab[r_row]  <= '0;
                        r_rpart[r_row] <= PTN_NONE;
                        r_cpart[r_row] <= PTN_NONE;
                        r_col          <= '0;
                        if (w_last_row) begin
                            r_round <= '0;
                            r_state <= S_ROUND;
                        end else begin
                            r_row   <= r_row + IDX_W'(1);
                            r_state <= S_INIT_RD;
                        end
                    end else begin
                        r_acc   <= (r_col == '0 || w_wd > r_acc) ? w_wd : r_acc;
                        r_col   <= r_col + IDX_W'(1);
                        r_state <= S_INIT_RD;
                    end
                end
                S_ROUND: begin
                    if (r_round == r_n) begin
                        r_row   <= '0;
                        r_total <= '0;
                        r_state <= S_SUM_RD;
                    end else begin
                        r_root     <= w_root;
                        r_queue[0] <= w_root;
                        r_qr       <= '0;
                        r_qw       <= N_W'(1);
                        r_guard    <= '0;
                        r_rtree    <= MAX_SIZE'(1) << w_root;
                        r_ctree    <= '0;
                        for (int i = 0; i < MAX_SIZE; i++) begin
                            r_tpar[i] <= (IDX_W'(i) == w_root) ? {1'b0, w_root} : PTN_NONE;
                        end
                        r_col   <= '0;
                        r_state <= S_RSL_RD;
                    end
                end
                S_RSL_RD: r_state <= S_RSL_EX;
                S_RSL_EX: begin
                    r_slack[r_col] <= w_rsl;
                    r_ssrc[r_col]  <= r_root;
                    if (w_last_col) begin
                        r_state <= S_POP;
                    end else begin
                        r_col   <= r_col + IDX_W'(1);
                        r_state <= S_RSL_RD;
                    end
                end
                S_POP: begin
                    r_col <= '0;
                    if (r_qr < r_qw) begin
                        r_cur   <= r_queue[r_qr[IDX_W-1:0]];
                        r_qr    <= r_qr + N_W'(1);
                        r_state <= S_BFS_RD;
                    end else begin
                        r_have  <= 1'b0;
                        r_delta <= '0;
                        r_state <= S_DMIN;
                    end
                end
                S_BFS_RD: r_state <= S_BFS_EX;
                S_BFS_EX: begin
                    if (!r_ctree[r_col] && w_wd == w_bfs_sum) begin
                        if (r_cpart[r_col][IDX_W]) begin
                            r_er    <= r_cur;
                            r_ec    <= r_col;
                            r_step  <= '0;
                            r_state <= S_AUG;
                        end else begin
                            // tight edge to a matched column: grow the tree
                            r_ctree[r_col] <= 1'b1;
                            if (r_qw < N_W'(MAX_SIZE)) begin
                                r_queue[r_qw[IDX_W-1:0]] <= w_p;
                                r_qw <= r_qw + N_W'(1);
                            end
                            r_rtree[w_p] <= 1'b1;
                            r_tpar[w_p]  <= {1'b0, r_cur};
                            r_gr         <= w_p;
                            r_gc         <= '0;
                            r_ret_zero   <= 1'b0;
                            r_state      <= S_GRW_RD;
                        end
                    end else if (w_last_col) begin
                        r_state <= S_POP;
                    end else begin
                        r_col   <= r_col + IDX_W'(1);
                        r_state <= S_BFS_RD;
                    end
                end
                S_GRW_RD: r_state <= S_GRW_EX;
                S_GRW_EX: begin
                    if (w_grw < r_slack[r_gc]) begin
                        r_slack[r_gc] <= w_grw;
                        r_ssrc[r_gc]  <= r_gr;
                    end
                    if (!w_last_gc) begin
                        r_gc    <= r_gc + IDX_W'(1);
                        r_state <= S_GRW_RD;
                    end else if (!r_ret_zero) begin
                        // resume the BFS scan after this column
                        if (w_last_col) begin
                            r_state <= S_POP;
                        end else begin
                            r_col   <= r_col + IDX_W'(1);
                            r_state <= S_BFS_RD;
                        end
                    end else if (!w_last_col) begin
                        r_col   <= r_col + IDX_W'(1);
                        r_state <= S_ZERO;
                    end else if (r_guard == r_n) begin
                        r_state <= S_SUM_RD;
                        r_row   <= '0;
                        r_total <= '0;
                    end else begin
                        r_guard <= r_guard + N_W'(1);
                        r_state <= S_POP;
                    end
                end
                S_DMIN: begin
                    if (!r_ctree[r_col] && (!r_have || r_slack[r_col] < r_delta)) begin
                        r_delta <= r_slack[r_col];
                        r_have  <= 1'b1;
                    end
                    if (w_last_col) begin
                        r_state <= S_DUPD;
                    end else begin
                        r_col <= r_col + IDX_W'(1);
                    end
                end
                S_DUPD: begin
                    for (int i = 0; i < MAX_SIZE; i++) begin
                        if (N_W'(i) < r_n) begin
                            if (r_rtree[i]) r_rlab[i] <= r_rlab[i] - r_delta;
                            if (r_ctree[i]) begin
                                r_clab[i] <= r_clab[i] + r_delta;
                            end else begin
                                r_slack[i] <= r_slack[i] - r_delta;
                            end
                        end
                    end
                    r_qr    <= '0;
                    r_qw    <= '0;
                    r_col   <= '0;
                    r_state <= S_ZERO;
                end
                S_ZERO: begin
                    if (!r_ctree[r_col] && r_slack[r_col] == '0 && r_cpart[r_col][IDX_W]) begin
                        r_er    <= w_src;
                        r_ec    <= r_col;
                        r_step  <= '0;
                        r_state <= S_AUG;
                    end else if (!r_ctree[r_col] && r_slack[r_col] == '0 && !r_rtree[w_p]) begin
                        // new zero-slack column with a row outside the tree
                        r_ctree[r_col] <= 1'b1;
                        if (r_qw < N_W'(MAX_SIZE)) begin
                            r_queue[r_qw[IDX_W-1:0]] <= w_p;
                            r_qw <= r_qw + N_W'(1);
                        end
                        r_rtree[w_p] <= 1'b1;
                        r_tpar[w_p]  <= {1'b0, w_src};
                        r_gr         <= w_p;
                        r_gc         <= '0;
                        r_ret_zero   <= 1'b1;
                        r_state      <= S_GRW_RD;
                    end else begin
                        if (!r_ctree[r_col] && r_slack[r_col] == '0) begin
                            r_ctree[r_col] <= 1'b1;
                        end
                        if (!w_last_col) begin
                            r_col <= r_col + IDX_W'(1);
                        end else if (r_guard == r_n) begin
                            r_state <= S_SUM_RD;
                            r_row   <= '0;
                            r_total <= '0;
                        end else begin
                            r_guard <= r_guard + N_W'(1);
                            r_state <= S_POP;
                        end
                    end
                end
                S_AUG: begin
                    r_cpart[r_ec] <= {1'b0, r_er};
                    r_rpart[r_er] <= {1'b0, r_ec};
                    if (w_aug_stop) begin
                        r_round <= r_round + N_W'(1);
                        r_state <= S_ROUND;
                    end else begin
                        r_er   <= w_par[IDX_W-1:0];
                        r_ec   <= w_nc[IDX_W-1:0];
                        r_step <= r_step + IDX_W'(1);
                    end
                end
                S_SUM_RD: r_state <= S_SUM_EX;
                S_SUM_EX: begin
                    r_total <= r_total + TOT_W'(w_orig);
                    if (w_last_row) begin
                        r_row   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_row   <= r_row + IDX_W'(1);
                        r_state <= S_SUM_RD;
                    end
                end
                S_OUT: begin
                    if (w_last_row) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_row <= r_row + IDX_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_go_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_go) |=> (r_state == S_CONV_RD))
        else $error("solve did not start after go");
    a_aug_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AUG) |-> ({1'b0, r_er} < r_n))
        else $error("augmenting path left the matrix");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_qw <= N_W'(MAX_SIZE)))
        else $error("search queue overrun");
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_result) |=> (!o_valid && r_state == S_IDLE))
        else $error("results continued after the last one");
`endif

endmodule
`default_nettype wire
